@@ rtl/rdq_pkg.sv @@
// Package for the ring deque with search: sizes, op codes, FSM states,
// controller/datapath command and status structs, ring and word helpers.
// No dependencies.
`default_nettype none

package rdq_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Port field widths
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND     = 2'd0,
        OP_TAKE_FRONT = 2'd1,
        OP_TAKE_BACK  = 2'd2,
        OP_QUERY      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TAKE,
        ST_SCAN,
        ST_OUT
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic in_ready;
        logic write_back;
        logic set_full;
        logic set_empty;
        logic read_take;
        logic take_commit;
        logic scan_start;
        logic scan_step;
        logic out_load;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic in_valid;
        t_op  op;
        logic is_full;
        logic count_zero;
        logic scan_done;
        logic out_free;
    } t_sts;

    // (a + b) mod DEPTH, both operands below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = (IDX_W+1)'(a) + (IDX_W+1)'(b);
        if (s >= (IDX_W+1)'(DEPTH)) begin
            s = s - (IDX_W+1)'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    // Input value truncated (or sign extended) to the stored word width
    function automatic logic [WORD_WIDTH-1:0] to_word(input logic signed [VALUE_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(v);
        return ext[WORD_WIDTH-1:0];
    endfunction

    // Stored word sign extended, reported as its low 32 bits
    function automatic logic [VALUE_W-1:0] to_out(input logic [WORD_WIDTH-1:0] w);
        logic signed [63:0] ext;
        ext = 64'(signed'(w));
        return ext[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/rdq_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on rdq_pkg for field widths.
`default_nettype none

interface rdq_req_if;
    logic                                  valid;
    logic                                  ready;
    logic [rdq_pkg::OP_W-1:0]              operation;
    logic signed [rdq_pkg::VALUE_W-1:0]    value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface rdq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rdq_pkg::VALUE_W-1:0]    taken_value;
    logic                                  found;
    logic                                  empty_error;
    logic                                  full_error;
    logic [rdq_pkg::COUNT_W-1:0]           entry_count;

    modport source (output valid, output taken_value, output found,
                    output empty_error, output full_error, output entry_count,
                    input ready);
    modport sink   (input valid, input taken_value, input found,
                    input empty_error, input full_error, input entry_count,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/rdq_ctrl.sv @@
// Controller FSM: sequences append, take and query items over the datapath.
// Depends on rdq_pkg.
`default_nettype none

module rdq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rdq_pkg::t_sts  i_sts,
    output rdq_pkg::t_cmd       o_cmd
);
    import rdq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_sts.op)
                    OP_APPEND: begin
                        if (i_sts.is_full) begin
                            o_cmd.set_full = 1'b1;
                        end else begin
                            o_cmd.write_back = 1'b1;
                        end
                        n_state = ST_OUT;
                    end
                    OP_TAKE_FRONT, OP_TAKE_BACK: begin
                        if (i_sts.count_zero) begin
                            o_cmd.set_empty = 1'b1;
                            n_state = ST_OUT;
                        end else begin
                            o_cmd.read_take = 1'b1;
                            n_state = ST_TAKE;
                        end
                    end
                    OP_QUERY: begin
                        o_cmd.scan_start = 1'b1;
                        n_state = ST_SCAN;
                    end
                    default: n_state = ST_OUT;
                endcase
            end
            ST_TAKE: begin
                o_cmd.take_commit = 1'b1;
                n_state = ST_OUT;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/rdq_dpath.sv @@
// Datapath: entry memory, ring pointers, scan counter and output register.
// Depends on rdq_pkg and the channel interfaces in rdq_if.sv.
`default_nettype none

module rdq_dpath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rdq_pkg::t_cmd  i_cmd,
    output rdq_pkg::t_sts       o_sts,
    rdq_req_if.sink             i_req,
    rdq_rsp_if.source           o_rsp
);
    import rdq_pkg::*;

    // Entry store
    logic [WORD_WIDTH-1:0] r_mem [DEPTH];
    logic [WORD_WIDTH-1:0] r_rdata;

    // Ring state
    logic [IDX_W-1:0]      r_front;
    logic [CNT_W-1:0]      r_count;

    // Current item and its result
    t_op                   r_op;
    logic [WORD_WIDTH-1:0] r_word;
    logic [WORD_WIDTH-1:0] r_taken;
    logic                  r_found;
    logic                  r_empty_err;
    logic                  r_full_err;

    // Query scan
    logic [CNT_W-1:0]      r_k;
    logic                  r_pend;

    // Output register
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_o_taken;
    logic                  r_o_found;
    logic                  r_o_empty;
    logic                  r_o_full;
    logic [COUNT_W-1:0]    r_o_count;

    logic                  in_fire;
    logic                  match;
    logic                  scan_end;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      back_addr;
    logic [63:0]           count_ext;

    assign in_fire   = i_req.valid && i_cmd.in_ready;
    assign match     = (r_rdata == r_word);
    assign scan_end  = (r_k == r_count);
    assign wr_addr   = ring_add(r_front, r_count[IDX_W-1:0]);
    assign back_addr = ring_add(r_front, r_count[IDX_W-1:0] - IDX_W'(1));
    assign count_ext = 64'(r_count);

    // One read port: take address or next scan position
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_front;
        if (i_cmd.read_take) begin
            rd_en = 1'b1;
            if (r_op == OP_TAKE_BACK) begin
                rd_addr = back_addr;
            end
        end else if (i_cmd.scan_step && !scan_end) begin
            rd_en   = 1'b1;
            rd_addr = ring_add(r_front, r_k[IDX_W-1:0]);
        end
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_back) begin
            r_mem[wr_addr] <= r_word;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Control state: pointers, scan progress, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.write_back) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.take_commit) begin
                r_count <= r_count - CNT_W'(1);
                if (r_op == OP_TAKE_FRONT) begin
                    r_front <= ring_add(r_front, IDX_W'(1));
                end
            end
            if (i_cmd.scan_start) begin
                r_k    <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pend <= !scan_end;
                if (!scan_end) begin
                    r_k <= r_k + CNT_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture and result build-up
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op        <= t_op'(i_req.operation);
            r_word      <= to_word(i_req.value);
            r_taken     <= '0;
            r_found     <= 1'b0;
            r_empty_err <= 1'b0;
            r_full_err  <= 1'b0;
        end
        if (i_cmd.set_full) begin
            r_full_err <= 1'b1;
        end
        if (i_cmd.set_empty) begin
            r_empty_err <= 1'b1;
        end
        if (i_cmd.take_commit) begin
            r_taken <= r_rdata;
        end
        if (i_cmd.scan_step && r_pend && match) begin
            r_found <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_taken <= to_out(r_taken);
            r_o_found <= r_found;
            r_o_empty <= r_empty_err;
            r_o_full  <= r_full_err;
            r_o_count <= count_ext[COUNT_W-1:0];
        end
    end

    // Status to the controller
    always_comb begin
        o_sts.in_valid   = i_req.valid;
        o_sts.op         = r_op;
        o_sts.is_full    = (r_count >= CNT_W'(DEPTH));
        o_sts.count_zero = (r_count == '0);
        o_sts.scan_done  = r_pend ? (match || scan_end) : scan_end;
        o_sts.out_free   = !r_out_valid || o_rsp.ready;
    end

    // Channel outputs
    assign i_req.ready       = i_cmd.in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.taken_value = r_o_taken;
    assign o_rsp.found       = r_o_found;
    assign o_rsp.empty_error = r_o_empty;
    assign o_rsp.full_error  = r_o_full;
    assign o_rsp.entry_count = r_o_count;

endmodule

`default_nettype wire

@@ rtl/ring_deque_with_search_core.sv @@
// Top level of the ring deque with search: controller plus datapath.
// Depends on rdq_pkg, rdq_if.sv, rdq_ctrl and rdq_dpath.
//
// A bounded double-ended store of 16 signed 32-bit words kept in a ring.
// Each request appends at the back, takes from the front or the back, or
// asks whether a value is held; each yields one result carrying the taken
// word (zero when nothing is taken), a found flag, empty and full error
// flags and the entry count after the request. Items are handled one at a
// time; a query compares the held entries one per cycle through the single
// read port of the entry memory. The next request is accepted while a
// finished result still waits in the output register. No clearing pass is
// needed after reset.
`default_nettype none

module ring_deque_with_search_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rdq_req_if.sink   i_req,
    rdq_rsp_if.source o_rsp
);
    import rdq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rdq_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

@@ rtl/rdq_checker.sv @@
// Port-level checks for ring_deque_with_search_core, bound to the top level.
// Depends on rdq_pkg.
`default_nettype none

module rdq_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_req_valid,
    input wire logic                          i_req_ready,
    input wire logic                          i_rsp_valid,
    input wire logic                          i_rsp_ready,
    input wire logic [rdq_pkg::VALUE_W-1:0]   i_rsp_taken,
    input wire logic                          i_rsp_found,
    input wire logic                          i_rsp_empty,
    input wire logic                          i_rsp_full,
    input wire logic [rdq_pkg::COUNT_W-1:0]   i_rsp_count
);
    import rdq_pkg::*;

    // A stalled result stays offered
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its payload
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable(i_rsp_taken) && $stable(i_rsp_count) && $stable(i_rsp_found))
        else $error("result payload changed while stalled");

    // At most one outcome flag per result
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> $onehot0({i_rsp_found, i_rsp_empty, i_rsp_full}))
        else $error("conflicting result flags");

    // An empty error leaves the store empty and takes nothing
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_empty |-> i_rsp_count == '0 && i_rsp_taken == '0)
        else $error("empty error with entries held");

    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while an item is in progress");

endmodule

bind ring_deque_with_search_core rdq_checker u_rdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_taken (o_rsp.taken_value),
    .i_rsp_found (o_rsp.found),
    .i_rsp_empty (o_rsp.empty_error),
    .i_rsp_full  (o_rsp.full_error),
    .i_rsp_count (o_rsp.entry_count)
);

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking bench for ring_deque_with_search_core: directed script, then random
// append/take/query traffic, checked against a behavioral model of the ring.
// Depends on rdq_pkg and the channel interfaces in rtl/rdq_if.sv.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rdq_pkg::*;

    localparam int RANDOM_ITEMS = 1920;
    localparam int TAIL_ITEMS   = 200;
    localparam int LONG_HOLD    = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE       = 40;
    localparam int PRINT_CAP    = 40;

    // One result as seen on the response channel
    typedef struct packed {
        logic [VALUE_W-1:0] taken;
        logic               found;
        logic               empty_err;
        logic               full_err;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    // Hand-written result that overrides the model for a scripted item
    typedef struct packed {
        logic     typed;
        t_outcome fixed;
    } t_mark;

    // Scripted item: repeats > 1 appends value, value-1, value-2, ...
    typedef struct packed {
        t_op                op;
        logic [VALUE_W-1:0] value;
        logic [4:0]         repeats;
        logic               typed;
        t_outcome           fixed;
    } t_step;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN,
        MIX_SEARCH
    } t_mix;

    localparam int SCRIPT_ROWS = 15;
    localparam t_step SCRIPT [SCRIPT_ROWS] = '{
        // empty store: query misses, both takes fail
        '{OP_QUERY,      32'h0000_0000, 5'd1,  1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 5'd0}},
        '{OP_TAKE_FRONT, 32'h0000_0000, 5'd1,  1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 5'd0}},
        '{OP_TAKE_BACK,  32'hFFFF_FFFF, 5'd1,  1'b1, '{32'h0, 1'b0, 1'b1, 1'b0, 5'd0}},
        // extremes in, found / not found
        '{OP_APPEND,     32'h7FFF_FFFF, 5'd1,  1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 5'd1}},
        '{OP_APPEND,     32'h8000_0000, 5'd1,  1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 5'd2}},
        '{OP_QUERY,      32'h8000_0000, 5'd1,  1'b1, '{32'h0, 1'b1, 1'b0, 1'b0, 5'd2}},
        '{OP_QUERY,      32'h7FFF_FFFE, 5'd1,  1'b1, '{32'h0, 1'b0, 1'b0, 1'b0, 5'd2}},
        // front take of a two-entry list must leave one entry
        '{OP_TAKE_FRONT, 32'h0000_0000, 5'd1,  1'b1,
          '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 5'd1}},
        // last entry taken from the back, front position kept
        '{OP_TAKE_BACK,  32'h0000_0000, 5'd1,  1'b1,
          '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 5'd0}},
        // fill to capacity across the wrap point
        '{OP_APPEND,     32'hFFFF_FFFF, 5'd16, 1'b0, '0},
        '{OP_APPEND,     32'h0000_0000, 5'd1,  1'b1, '{32'h0, 1'b0, 1'b0, 1'b1, 5'd16}},
        '{OP_QUERY,      32'hFFFF_FFF0, 5'd1,  1'b0, '0},
        '{OP_TAKE_FRONT, 32'h0000_0000, 5'd1,  1'b0, '0},
        '{OP_TAKE_BACK,  32'h0000_0000, 5'd1,  1'b0, '0},
        '{OP_QUERY,      32'hFFFF_FFFF, 5'd1,  1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rdq_req_if req ();
    rdq_rsp_if rsp ();

    ring_deque_with_search_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    // Model state of the ring
    logic [WORD_WIDTH-1:0] ring_words [DEPTH];
    int unsigned           ring_head = 0;
    int unsigned           ring_held = 0;

    t_outcome    outcomes_due [$];
    t_mark       typed_marks [$];
    logic [31:0] recent_words [$];

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned req_idle_pct   = 0;
    int unsigned rsp_idle_pct   = 0;
    int unsigned holds_asked    = 0;
    int unsigned holds_served   = 0;
    bit          quiet_tail     = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one request to the model ring and return its result
    function automatic t_outcome apply_request(input t_op op,
                                               input logic signed [VALUE_W-1:0] v);
        t_outcome              r;
        logic signed [63:0]    wide;
        logic signed [63:0]    back;
        logic [WORD_WIDTH-1:0] word;
        int unsigned           slot;
        r    = '0;
        wide = v;
        word = wide[WORD_WIDTH-1:0];
        case (op)
            OP_APPEND: begin
                if (ring_held >= DEPTH) begin
                    r.full_err = 1'b1;
                end else begin
                    ring_words[(ring_head + ring_held) % DEPTH] = word;
                    ring_held++;
                end
            end
            OP_TAKE_FRONT, OP_TAKE_BACK: begin
                if (ring_held == 0) begin
                    r.empty_err = 1'b1;
                end else begin
                    slot = (op == OP_TAKE_FRONT) ? ring_head
                                                 : (ring_head + ring_held - 1) % DEPTH;
                    back    = signed'(ring_words[slot]);
                    r.taken = back[VALUE_W-1:0];
                    if (op == OP_TAKE_FRONT) begin
                        ring_head = (ring_head + 1) % DEPTH;
                    end
                    ring_held--;
                end
            end
            default: begin
                for (int k = 0; k < ring_held; k++) begin
                    if (ring_words[(ring_head + k) % DEPTH] == word) begin
                        r.found = 1'b1;
                    end
                end
            end
        endcase
        r.count = COUNT_W'(ring_held);
        return r;
    endfunction

    function automatic t_op pick_op(input t_mix mix);
        int unsigned roll;
        int unsigned w_app;
        int unsigned w_take;
        roll = $urandom_range(99);
        case (mix)
            MIX_FILL:  begin w_app = 60; w_take = 20; end
            MIX_DRAIN: begin w_app = 15; w_take = 65; end
            MIX_EVEN:  begin w_app = 35; w_take = 35; end
            default:   begin w_app = 30; w_take = 20; end
        endcase
        if (roll < w_app) begin
            return OP_APPEND;
        end else if (roll < w_app + w_take / 2) begin
            return OP_TAKE_FRONT;
        end else if (roll < w_app + w_take) begin
            return OP_TAKE_BACK;
        end
        return OP_QUERY;
    endfunction

    // Mix of extremes, a narrow range that repeats, and full-width words;
    // queries often look for a word appended recently
    function automatic logic [31:0] pick_value(input t_op op);
        int unsigned roll;
        roll = $urandom_range(99);
        if (op == OP_QUERY && recent_words.size() != 0 && roll < 50) begin
            return recent_words[$urandom_range(recent_words.size() - 1)];
        end
        roll = $urandom_range(99);
        if (roll < 10) begin
            case ($urandom_range(4))
                0:       return 32'h0000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h8000_0000;
                3:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end else if (roll < 45) begin
            return 32'($signed($urandom_range(0, 31)) - 16);
        end
        return $urandom;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        end
    endtask

    // Offer one item, with an optional idle burst in front of it
    task automatic offer_item(input t_op op, input logic [31:0] v, input logic typed,
                              input t_outcome fixed);
        int unsigned gap;
        if (!quiet_tail && $urandom_range(99) < req_idle_pct) begin
            gap = $urandom_range(1, 5);
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        typed_marks.push_back('{typed, fixed});
        req.valid     <= 1'b1;
        req.operation <= op;
        req.value     <= v;
        do @(posedge i_clk); while (!req.ready);
    endtask

    task automatic await_drain();
        req.valid <= 1'b0;
        do @(posedge i_clk); while (outcomes_due.size() != 0);
    endtask

    // Predict on every accepted item
    always @(posedge i_clk) begin : request_watch
        t_outcome predicted;
        t_mark    mark;
        if (i_rst_n && req.valid && req.ready) begin
            predicted = apply_request(t_op'(req.operation), req.value);
            mark      = typed_marks.pop_front();
            outcomes_due.push_back(mark.typed ? mark.fixed : predicted);
        end
    end

    // Compare every accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_watch
        t_outcome want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (outcomes_due.size() == 0) begin
                flag_mismatch("unexpected result", rsp.taken_value, 32'h0);
            end else begin
                want = outcomes_due.pop_front();
                if (rsp.taken_value !== want.taken) begin
                    flag_mismatch("taken_value", rsp.taken_value, want.taken);
                end
                if (rsp.found !== want.found) begin
                    flag_mismatch("found", 32'(rsp.found), 32'(want.found));
                end
                if (rsp.empty_error !== want.empty_err) begin
                    flag_mismatch("empty_error", 32'(rsp.empty_error), 32'(want.empty_err));
                end
                if (rsp.full_error !== want.full_err) begin
                    flag_mismatch("full_error", 32'(rsp.full_error), 32'(want.full_err));
                end
                if (rsp.entry_count !== want.count) begin
                    flag_mismatch("entry_count", 32'(rsp.entry_count), 32'(want.count));
                end
            end
        end
    end

    // Cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stall bursts, rate changed now and then, long holds on request
    initial begin : result_sink
        int unsigned tick;
        int unsigned gap;
        tick = 0;
        rsp.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (tick % 97 == 0) begin
                case ($urandom_range(2))
                    0:       rsp_idle_pct = 0;
                    1:       rsp_idle_pct = 15;
                    default: rsp_idle_pct = 40;
                endcase
            end
            if (holds_served != holds_asked) begin
                holds_served++;
                rsp.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rsp.ready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(99) < rsp_idle_pct) begin
                gap = $urandom_range(1, 5);
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                rsp.ready <= 1'b1;
            end else begin
                rsp.ready <= 1'b1;
            end
        end
    end

    // Sender: reset, directed script, random phases, then wind down
    initial begin : request_source
        int unsigned sent;
        int unsigned phase;
        int unsigned span;
        t_mix        mix;
        t_op         op;
        logic [31:0] v;
        req.valid     = 1'b0;
        req.operation = OP_APPEND;
        req.value     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part
        req_idle_pct = 20;
        for (int r = 0; r < SCRIPT_ROWS; r++) begin
            for (int k = 0; k < SCRIPT[r].repeats; k++) begin
                offer_item(SCRIPT[r].op, SCRIPT[r].value - k, SCRIPT[r].typed,
                           SCRIPT[r].fixed);
            end
        end
        await_drain();

        // Random part in phases of varying mix and idle rate
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            mix  = t_mix'($urandom_range(3));
            span = $urandom_range(30, 120);
            case ($urandom_range(3))
                0:       req_idle_pct = 0;
                1:       req_idle_pct = 10;
                2:       req_idle_pct = 30;
                default: req_idle_pct = 60;
            endcase
            // receiver holds off while items keep coming
            if (phase == 3 || phase == 11) begin
                holds_asked++;
            end
            for (int i = 0; i < span && sent < RANDOM_ITEMS; i++) begin
                if (RANDOM_ITEMS - sent <= TAIL_ITEMS) begin
                    quiet_tail = 1'b1;
                end
                op = pick_op(mix);
                v  = pick_value(op);
                if (op == OP_APPEND) begin
                    recent_words.push_back(v);
                    if (recent_words.size() > 32) begin
                        void'(recent_words.pop_front());
                    end
                end
                offer_item(op, v, 1'b0, '0);
                sent++;
            end
            // sender pauses until every outstanding result is back
            if (phase % 5 == 2 && !quiet_tail) begin
                await_drain();
            end
            phase++;
        end

        await_drain();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatch_count == 0 && outcomes_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rdq_pkg.sv
rtl/rdq_if.sv
rtl/rdq_ctrl.sv
rtl/rdq_dpath.sv
rtl/ring_deque_with_search_core.sv
rtl/rdq_checker.sv
verif/testbench.sv
